FILE: hw/rtl/efs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// efs_pkg: shared types and constants of the frame scheduler
// Event codes, frame kinds, register indexes, counter widths and the reset
// values of the timing registers.
// ----------------------------------------------------------------------------
package efs_pkg;

  localparam int unsigned MsW    = 10;
  localparam int unsigned RepW   = 4;
  localparam int unsigned OpW    = 2;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned KindW  = 3;
  localparam int unsigned CfgAW  = 3;
  localparam int unsigned CfgDW  = 10;
  localparam int unsigned InDW   = 8;
  localparam int unsigned OutDW  = 8;

  typedef logic [MsW-1:0]   ms_t;
  typedef logic [RepW-1:0]  rep_t;
  typedef logic [ModeW-1:0] mode_t;

  typedef enum logic [OpW-1:0] {
    OpTick    = 2'd0,
    OpPowerOn = 2'd1,
    OpPowerOff = 2'd2,
    OpSetMode = 2'd3
  } op_e;

  typedef enum logic [KindW-1:0] {
    KindWake     = 3'd0,
    KindRunCtrl  = 3'd1,
    KindRunSetp  = 3'd2,
    KindStopCtrl = 3'd3,
    KindStopSetp = 3'd4
  } kind_e;

  localparam mode_t ModeEco  = 2'd0;
  localparam mode_t ModeHigh = 2'd2;

  localparam logic [CfgAW-1:0] CfgCyclePeriod  = 3'd0;
  localparam logic [CfgAW-1:0] CfgCtrlSetpGap  = 3'd1;
  localparam logic [CfgAW-1:0] CfgStopGap      = 3'd2;
  localparam logic [CfgAW-1:0] CfgStopInterval = 3'd3;
  localparam logic [CfgAW-1:0] CfgStopRepeat   = 3'd4;

  localparam ms_t  CntMax            = '1;
  localparam ms_t  RstCyclePeriod    = 10'd50;
  localparam ms_t  RstCtrlSetpGap    = 10'd25;
  localparam ms_t  RstStopGap        = 10'd25;
  localparam ms_t  RstStopInterval   = 10'd75;
  localparam rep_t RstStopRepeat     = 4'd3;

  // saturating millisecond count
  function automatic ms_t sat_inc(input ms_t v);
    return (v == CntMax) ? CntMax : ms_t'(v + 1'b1);
  endfunction

endpackage : efs_pkg
`default_nettype wire

FILE: hw/rtl/esc_frame_scheduler.sv
`default_nettype none
// Path: an accepted word is held in the input register, its frame (if any)
//   in the result register; words that cause no frame are dropped silently.
// Throughput: one word per cycle unless a frame stalls; the input and the
//   result register part the two sides, so a stalled frame does not stop acceptance at once.
// Reset: rst_ni clears all scheduler state and loads the timing defaults.
// ----------------------------------------------------------------------------
// esc_frame_scheduler: frame scheduler for a motor controller link
// Takes tick / power on / power off / set mode words and decides which frame
// (wake, run CTRL/SETP, stop CTRL/SETP) goes out, from saturating ms counters.
// ----------------------------------------------------------------------------
module esc_frame_scheduler (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [efs_pkg::CfgAW-1:0]     cfg_addr_i,
  input  wire logic [efs_pkg::CfgDW-1:0]     cfg_wdata_i,
  // event stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [efs_pkg::InDW-1:0]      s_axis_tdata,  // [1:0] mode_code, rest 0
  input  wire logic [efs_pkg::OpW-1:0]       s_axis_tuser,  // [1:0] op
  // frame stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [efs_pkg::OutDW-1:0]          m_axis_tdata,  // [1:0] frame_mode, [2] motor_running
  output logic [efs_pkg::KindW-1:0]          m_axis_tuser   // [2:0] frame_kind
);
  import efs_pkg::*;

  typedef enum logic [1:0] {
    StopNone    = 2'd0,
    StopSetpDue = 2'd1,
    StopCtrlDue = 2'd2
  } stop_ph_e;

  // configuration
  ms_t  cyc_period_q, setp_gap_q, stop_gap_q, stop_int_q;
  rep_t stop_rep_q;

  // input register
  logic  in_vld_q, in_vld_d;
  op_e   in_op_q;
  mode_t in_mode_q;
  logic  advance;

  // scheduler state
  logic     motor_on_q, motor_on_d;
  mode_t    cur_mode_q, cur_mode_d;
  logic     wake_done_q, wake_done_d;
  logic     wake_pend_q, wake_pend_d;
  ms_t      wake_el_q, wake_el_d;
  ms_t      cyc_el_q, cyc_el_d;
  ms_t      ph_el_q, ph_el_d;
  logic     run_ph_q, run_ph_d;
  stop_ph_e stop_ph_q, stop_ph_d;
  rep_t     stop_sent_q, stop_sent_d;
  ms_t      stop_el_q, stop_el_d;

  // result
  logic  res_vld;
  kind_e res_kind;
  mode_t res_mode;
  logic  out_vld_q, out_vld_d;
  kind_e out_kind_q;
  mode_t out_mode_q;
  logic  out_run_q;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    logic run_ok;
    rep_t sent_inc;

    motor_on_d  = motor_on_q;
    cur_mode_d  = cur_mode_q;
    wake_done_d = wake_done_q;
    wake_pend_d = wake_pend_q;
    wake_el_d   = wake_el_q;
    cyc_el_d    = cyc_el_q;
    ph_el_d     = ph_el_q;
    run_ph_d    = run_ph_q;
    stop_ph_d   = stop_ph_q;
    stop_sent_d = stop_sent_q;
    stop_el_d   = stop_el_q;
    res_vld     = 1'b0;
    res_kind    = KindWake;
    res_mode    = ModeEco;
    run_ok      = 1'b1;
    sent_inc    = rep_t'(stop_sent_q + 1'b1);

    if (advance) begin
      case (in_op_q)
        OpTick: begin
          wake_el_d = sat_inc(wake_el_q);
          cyc_el_d  = sat_inc(cyc_el_q);
          ph_el_d   = sat_inc(ph_el_q);
          stop_el_d = sat_inc(stop_el_q);
          case (stop_ph_q)
            StopSetpDue: begin
              if (stop_el_d >= stop_gap_q) begin
                stop_sent_d = sent_inc;
                if (sent_inc >= stop_rep_q) begin
                  stop_ph_d = StopNone;
                end else begin
                  stop_ph_d = StopCtrlDue;
                  stop_el_d = '0;
                end
                res_vld  = 1'b1;
                res_kind = KindStopSetp;
              end
            end
            StopCtrlDue: begin
              if (stop_el_d >= stop_int_q) begin
                stop_ph_d = StopSetpDue;
                stop_el_d = '0;
                res_vld   = 1'b1;
                res_kind  = KindStopCtrl;
                res_mode  = cur_mode_q;
              end
            end
            default: begin
              // finish the wake gap before any run frame
              if (wake_pend_q) begin
                if (wake_el_d < stop_gap_q) begin
                  run_ok = 1'b0;
                end else begin
                  wake_pend_d = 1'b0;
                  wake_done_d = 1'b1;
                  cyc_el_d    = CntMax;
                  run_ph_d    = 1'b0;
                end
              end
              if (run_ok && motor_on_q) begin
                if (!run_ph_d) begin
                  if (cyc_el_d >= cyc_period_q) begin
                    ph_el_d  = '0;
                    run_ph_d = 1'b1;
                    res_vld  = 1'b1;
                    res_kind = KindRunCtrl;
                    res_mode = cur_mode_q;
                  end
                end else if (ph_el_d >= setp_gap_q) begin
                  cyc_el_d = '0;
                  run_ph_d = 1'b0;
                  res_vld  = 1'b1;
                  res_kind = KindRunSetp;
                  res_mode = cur_mode_q;
                end
              end
            end
          endcase
        end
        OpPowerOn: begin
          stop_ph_d  = StopNone;
          motor_on_d = 1'b1;
          run_ph_d   = 1'b0;
          cyc_el_d   = CntMax;
          if (!wake_done_q) begin
            wake_pend_d = 1'b1;
            wake_el_d   = '0;
            res_vld     = 1'b1;
            res_kind    = KindWake;
          end
        end
        OpPowerOff: begin
          motor_on_d  = 1'b0;
          wake_pend_d = 1'b0;
          stop_sent_d = '0;
          stop_ph_d   = StopSetpDue;
          stop_el_d   = '0;
          res_vld     = 1'b1;
          res_kind    = KindStopCtrl;
          res_mode    = cur_mode_q;
        end
        default: begin
          cur_mode_d = (in_mode_q > ModeHigh) ? ModeHigh : in_mode_q;
        end
      endcase
    end
  end

  always_comb begin
    out_vld_d = out_vld_q && !m_axis_tready;
    if (advance) begin
      out_vld_d = res_vld;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyc_period_q <= RstCyclePeriod;
      setp_gap_q   <= RstCtrlSetpGap;
      stop_gap_q   <= RstStopGap;
      stop_int_q   <= RstStopInterval;
      stop_rep_q   <= RstStopRepeat;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgCyclePeriod:  cyc_period_q <= ms_t'(cfg_wdata_i);
        CfgCtrlSetpGap:  setp_gap_q   <= ms_t'(cfg_wdata_i);
        CfgStopGap:      stop_gap_q   <= ms_t'(cfg_wdata_i);
        CfgStopInterval: stop_int_q   <= ms_t'(cfg_wdata_i);
        CfgStopRepeat:   stop_rep_q   <= cfg_wdata_i[RepW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      motor_on_q  <= 1'b0;
      cur_mode_q  <= ModeEco;
      wake_done_q <= 1'b0;
      wake_pend_q <= 1'b0;
      wake_el_q   <= '0;
      cyc_el_q    <= '0;
      ph_el_q     <= '0;
      run_ph_q    <= 1'b0;
      stop_ph_q   <= StopNone;
      stop_sent_q <= '0;
      stop_el_q   <= '0;
    end else begin
      in_vld_q    <= in_vld_d;
      out_vld_q   <= out_vld_d;
      motor_on_q  <= motor_on_d;
      cur_mode_q  <= cur_mode_d;
      wake_done_q <= wake_done_d;
      wake_pend_q <= wake_pend_d;
      wake_el_q   <= wake_el_d;
      cyc_el_q    <= cyc_el_d;
      ph_el_q     <= ph_el_d;
      run_ph_q    <= run_ph_d;
      stop_ph_q   <= stop_ph_d;
      stop_sent_q <= stop_sent_d;
      stop_el_q   <= stop_el_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q   <= op_e'(s_axis_tuser);
      in_mode_q <= s_axis_tdata[ModeW-1:0];
    end
    if (advance && res_vld) begin
      out_kind_q <= res_kind;
      out_mode_q <= res_mode;
      out_run_q  <= motor_on_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {{(OutDW-ModeW-1){1'b0}}, out_run_q, out_mode_q};

endmodule : esc_frame_scheduler
`default_nettype wire

FILE: hw/rtl/efs_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// efs_checker: port-level checks of the frame scheduler
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module efs_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       s_axis_tvalid,
  input wire logic                       s_axis_tready,
  input wire logic                       m_axis_tvalid,
  input wire logic                       m_axis_tready,
  input wire logic [efs_pkg::OutDW-1:0]  m_axis_tdata,
  input wire logic [efs_pkg::KindW-1:0]  m_axis_tuser
);
  import efs_pkg::*;

  logic run_kind;
  logic s_acc;

  assign run_kind = (m_axis_tuser == KindWake) || (m_axis_tuser == KindRunCtrl) ||
                    (m_axis_tuser == KindRunSetp);
  assign s_acc    = s_axis_tvalid && s_axis_tready;

  // hold a stalled frame word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("frame word changed while stalled");

  // run and wake frames go out only with the motor on, stop frames with it off
  a_run_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[ModeW] == run_kind))
    else $error("motor_running does not match frame kind");

  // wake and stop SETP carry no mode; no mode above high
  a_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[ModeW-1:0] <= ModeHigh) &&
      (((m_axis_tuser != KindWake) && (m_axis_tuser != KindStopSetp)) ||
       (m_axis_tdata[ModeW-1:0] == ModeEco)))
    else $error("bad frame mode");

  // a new frame must trace back to an accepted event word, through the input and result registers
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_acc, 2))
    else $error("frame without an event word");

endmodule : efs_checker

bind esc_frame_scheduler efs_checker u_efs_checker (.*);
`default_nettype wire
